### src/assert_macros.svh
// assertion macros shared by the checker files
// depends on nothing; expects clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tif_pkg.sv
// telnet iac filter: shared constants, codes and types
// depends on nothing
package tif_pkg;

  localparam int BYTE_W  = 8;
  localparam int FLAGS_W = 6;
  localparam int OPT_W   = 3;
  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 4;
  localparam int CNT_W   = $clog2(QDEPTH + 1);
  localparam int NRES_W  = $clog2(MAX_RES + 1);

  localparam logic [BYTE_W-1:0] IAC      = 8'hff;
  localparam logic [BYTE_W-1:0] CMD_GA   = 8'd249;
  localparam logic [BYTE_W-1:0] CMD_SB   = 8'd250;
  localparam logic [BYTE_W-1:0] CMD_WILL = 8'd251;
  localparam logic [BYTE_W-1:0] CMD_WONT = 8'd252;
  localparam logic [BYTE_W-1:0] CMD_DO   = 8'd253;
  localparam logic [BYTE_W-1:0] CMD_DONT = 8'd254;

  localparam logic [BYTE_W-1:0] OPT_BINARY = 8'd0;
  localparam logic [BYTE_W-1:0] OPT_ECHO   = 8'd1;
  localparam logic [BYTE_W-1:0] OPT_SGA    = 8'd3;

  localparam logic [OPT_W-1:0] BIT_BINARY = 3'b001;
  localparam logic [OPT_W-1:0] BIT_ECHO   = 3'b010;
  localparam logic [OPT_W-1:0] BIT_SGA    = 3'b100;

  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_SESSION = 1'b1;

  typedef struct packed {
    logic              in_seq;
    logic              have_cmd;
    logic [BYTE_W-1:0] cmd;
    logic [OPT_W-1:0]  peer;
    logic [OPT_W-1:0]  own;
  } state_t;

  typedef struct packed {
    logic               to_network;
    logic [BYTE_W-1:0]  out_byte;
    logic [FLAGS_W-1:0] option_flags;
    logic               last;
  } res_t;

endpackage

### src/tif_item_if.sv
// input channel: received byte or session reset, valid/ready handshake
// depends on tif_pkg
interface tif_item_if;
  import tif_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] rx_byte;
  logic              chunk_end;

  modport source (output valid, op, rx_byte, chunk_end, input ready);
  modport sink   (input valid, op, rx_byte, chunk_end, output ready);
endinterface

### src/tif_result_if.sv
// result channel: data byte or negotiation reply byte, valid/ready handshake
// depends on tif_pkg
interface tif_result_if;
  import tif_pkg::*;

  logic               valid;
  logic               ready;
  logic               to_network;
  logic [BYTE_W-1:0]  out_byte;
  logic [FLAGS_W-1:0] option_flags;
  logic               last;

  modport source (output valid, to_network, out_byte, option_flags, last, input ready);
  modport sink   (input valid, to_network, out_byte, option_flags, last, output ready);
endinterface

### src/tif_step.sv
// one-byte step of the iac parser: next negotiation state and up to three results
// depends on tif_pkg
module tif_step (
  input  tif_pkg::state_t                      state,
  input  logic                                 op,
  input  logic [tif_pkg::BYTE_W-1:0]           rx_byte,
  output tif_pkg::state_t                      state_next,
  output logic [tif_pkg::NRES_W-1:0]           nres,
  output tif_pkg::res_t [tif_pkg::MAX_RES-1:0] res
);
  import tif_pkg::*;

  logic [OPT_W-1:0]  opt_bit;
  logic              send_data;
  logic              send_reply;
  logic [BYTE_W-1:0] verb;
  logic [FLAGS_W-1:0] flags;

  always_comb begin
    unique case (rx_byte)
      OPT_BINARY: opt_bit = BIT_BINARY;
      OPT_ECHO:   opt_bit = BIT_ECHO;
      OPT_SGA:    opt_bit = BIT_SGA;
      default:    opt_bit = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    send_data  = 1'b0;
    send_reply = 1'b0;
    verb       = CMD_WONT;
    if (op == OP_SESSION) begin
      state_next = '0;
    end else if (!state.in_seq) begin
      if (rx_byte == IAC) begin
        state_next.in_seq = 1'b1;
      end else begin
        send_data = 1'b1;
      end
    end else if (!state.have_cmd) begin
      if (rx_byte == CMD_GA) begin
        state_next.in_seq = 1'b0;
      end else begin
        state_next.cmd      = rx_byte;
        state_next.have_cmd = 1'b1;
        if (state.peer[0] && rx_byte == IAC) begin
          state_next.in_seq   = 1'b0;
          state_next.have_cmd = 1'b0;
          send_data           = 1'b1;
        end
      end
    end else begin
      state_next.in_seq   = 1'b0;
      state_next.have_cmd = 1'b0;
      if (opt_bit == '0) begin
        send_reply = state.cmd > CMD_SB;
      end else if (state.cmd == CMD_WILL) begin
        state_next.peer = state.peer | opt_bit;
      end else if (state.cmd == CMD_WONT) begin
        state_next.peer = state.peer & ~opt_bit;
      end else if (state.cmd == CMD_DO || state.cmd == CMD_DONT) begin
        send_reply = 1'b1;
        if (opt_bit == BIT_BINARY) begin
          if (state.cmd == CMD_DO) begin
            state_next.own = state.own | BIT_BINARY;
            verb           = CMD_WILL;
          end else begin
            state_next.own = state.own & ~BIT_BINARY;
          end
        end else if (opt_bit == BIT_ECHO) begin
          state_next.own = state.own & ~BIT_ECHO;
        end else begin
          state_next.own = state.own | BIT_SGA;
          verb           = CMD_WILL;
        end
      end
    end
  end

  // reply option byte: binary answers carry option 0, others echo the request
  always_comb begin
    flags = {state_next.own, state_next.peer};
    res   = '0;
    nres  = '0;
    if (send_data) begin
      nres   = NRES_W'(1);
      res[0] = '{to_network: 1'b0, out_byte: rx_byte, option_flags: flags, last: 1'b1};
    end else if (send_reply) begin
      nres   = NRES_W'(MAX_RES);
      res[0] = '{to_network: 1'b1, out_byte: IAC, option_flags: flags, last: 1'b0};
      res[1] = '{to_network: 1'b1, out_byte: verb, option_flags: flags, last: 1'b0};
      res[2] = '{to_network: 1'b1, out_byte: rx_byte, option_flags: flags, last: 1'b1};
    end
  end

endmodule

### src/telnet_iac_filter_top.sv
// telnet iac option-negotiation filter, top level
// depends on tif_pkg, tif_item_if, tif_result_if, tif_step
//
// item channel: one received byte per transfer (op data), or a session reset
//   (op session) that clears all negotiation state and gives no result
// result channel: data bytes for the serial side (to_network low) and
//   three-byte iac replies for the network (to_network high); last marks the
//   final result of each input byte, option_flags shows the flags after it
// results are registered in the result queue before they reach the result channel
// throughput: one input byte per cycle while results drain at one per cycle;
//   a reply leaves byte by byte through the single output port of the
//   four-entry result queue, and input waits while more than one entry is held
// reset (rst, synchronous): parser state, flags and result queue are cleared
// receiver stall: results stay in the queue, held stable on the channel;
//   item ready drops once the queue cannot take a full reply
module telnet_iac_filter_top (
  input  logic    clk,
  input  logic    rst,
  tif_item_if.sink     item,
  tif_result_if.source result
);
  import tif_pkg::*;

  state_t                    state;
  state_t                    state_next;
  logic [NRES_W-1:0]         nres;
  res_t [MAX_RES-1:0]        res;
  res_t [QDEPTH-1:0]         queue;
  res_t [QDEPTH-1:0]         queue_next;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          cnt_next;
  logic [CNT_W-1:0]          base;
  logic [CNT_W-1:0]          npush;
  logic [CNT_W-1:0]          rel;
  logic                      take;
  logic                      pop;

  tif_step u_step (
    .state      (state),
    .op         (item.op),
    .rx_byte    (item.rx_byte),
    .state_next (state_next),
    .nres       (nres),
    .res        (res)
  );

  assign item.ready = cnt <= CNT_W'(QDEPTH - MAX_RES);
  assign take       = item.valid && item.ready;
  assign pop        = result.valid && result.ready;

  assign result.valid        = cnt != '0;
  assign result.to_network   = queue[0].to_network;
  assign result.out_byte     = queue[0].out_byte;
  assign result.option_flags = queue[0].option_flags;
  assign result.last         = queue[0].last;

  always_comb begin
    base     = cnt - CNT_W'(pop);
    npush    = take ? CNT_W'(nres) : '0;
    cnt_next = base + npush;
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        queue_next[i] = queue[i + 1];
      end else begin
        queue_next[i] = queue[i];
      end
      rel = CNT_W'(i) - base;
      if (CNT_W'(i) >= base && rel < npush) begin
        queue_next[i] = res[rel[NRES_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      cnt   <= '0;
    end else begin
      if (take) begin
        state <= state_next;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    queue <= queue_next;
  end

endmodule

### src/tif_checker.sv
// port-level checks for the telnet iac filter, bound to the top level
// depends on assert_macros.svh and telnet_iac_filter_top
`include "assert_macros.svh"

module tif_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       item_op,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_to_network,
  input logic [7:0] res_out_byte,
  input logic       res_last
);

  `ASSERT_ALL(a_reset_empty, rst |=> !res_valid, "result valid right after reset")
  `ASSERT_CLK(a_stall_hold, res_valid && !res_ready |=> res_valid && $stable(res_out_byte), "stalled result changed")
  `ASSERT_CLK(a_data_last, res_valid && !res_to_network |-> res_last, "serial data byte without last")
  `ASSERT_CLK(a_session_quiet, item_valid && item_ready && item_op && !res_valid |=> !res_valid, "session reset produced a result")

endmodule

bind telnet_iac_filter_top tif_checker u_tif_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .item_op        (item.op),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_to_network (result.to_network),
  .res_out_byte   (result.out_byte),
  .res_last       (result.last)
);
